// ----- rtl/core/nbh_pkg.sv -----
// Shared constants, codes and types of the net bounding box and wirelength engine.
package nbh_pkg;

    localparam int INST_DEPTH  = 1024;
    localparam int INST_AW     = $clog2(INST_DEPTH);
    localparam int IDX_W       = 10;
    localparam int COORD_W     = 32;
    localparam int TAG_W       = 16;
    localparam int WL_W        = 33;
    localparam int PLACE_W     = 2 * COORD_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] MODE_MOVE  = 2'd0;
    localparam logic [1:0] MODE_PIN   = 2'd1;
    localparam logic [1:0] MODE_EMPTY = 2'd2;

    // One job for the back end: a resolved pin position or an empty net.
    typedef struct packed {
        logic               is_empty;
        logic               last;
        logic [TAG_W-1:0]   tag;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
    } t_job;

    // Handshake between the front end and the queue, and the queue and the back end.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_beat;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_y;
    } t_box;

endpackage

// ----- rtl/core/nbh_pin_if.sv -----
// Input channel carrying move, pin and empty-net beats.
interface nbh_pin_if import nbh_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                mode;
    logic [IDX_W-1:0]          inst_index;
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic signed [COORD_W-1:0] pin_off_x;
    logic signed [COORD_W-1:0] pin_off_y;
    logic                      last_pin;
    logic [TAG_W-1:0]          net_tag;

    modport source (
        output valid, mode, inst_index, new_x, new_y, pin_off_x, pin_off_y, last_pin,
               net_tag,
        input  ready
    );
    modport sink (
        input  valid, mode, inst_index, new_x, new_y, pin_off_x, pin_off_y, last_pin,
               net_tag,
        output ready
    );
endinterface

// ----- rtl/core/nbh_res_if.sv -----
// Output channel carrying one bounding box and wirelength per beat.
interface nbh_res_if import nbh_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [TAG_W-1:0]          net_tag_out;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_max_y;
    logic [WL_W-1:0]           wirelength;

    modport source (
        output valid, net_tag_out, box_min_x, box_max_x, box_min_y, box_max_y, wirelength,
        input  ready
    );
    modport sink (
        input  valid, net_tag_out, box_min_x, box_max_x, box_min_y, box_max_y, wirelength,
        output ready
    );
endinterface

// ----- rtl/core/nbh_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module nbh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/nbh_front.sv -----
// Front end: accepts beats, updates the placement table and resolves pin positions.
module nbh_front import nbh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nbh_pin_if.sink    s_pin,
    input  logic       i_push_ready,
    output t_job_beat  o_push
);

    logic                accept;
    logic                in_range;
    logic                fwd;
    logic                ram_we;
    logic                ram_re;
    logic [INST_AW-1:0]  addr;
    logic [PLACE_W-1:0]  rdata;
    logic [COORD_W-1:0]  base_x;
    logic [COORD_W-1:0]  base_y;

    logic                r_s1_valid;
    logic                r_s1_empty;
    logic                r_s1_in_range;
    logic                r_s1_last;
    logic [TAG_W-1:0]    r_s1_tag;
    logic [COORD_W-1:0]  r_s1_off_x;
    logic [COORD_W-1:0]  r_s1_off_y;

    assign s_pin.ready = !r_s1_valid || i_push_ready;
    assign accept      = s_pin.valid && s_pin.ready;
    assign in_range    = 32'(s_pin.inst_index) < 32'(INST_DEPTH);
    assign addr        = INST_AW'(s_pin.inst_index);
    assign fwd         = (s_pin.mode == MODE_PIN) || (s_pin.mode == MODE_EMPTY);
    assign ram_we      = accept && (s_pin.mode == MODE_MOVE) && in_range;
    assign ram_re      = accept && (s_pin.mode == MODE_PIN);

    // A move and a later pin of the same instance never collide: items are
    // accepted at most one per cycle, so the write lands before the read.
    nbh_ram #(
        .WIDTH (PLACE_W),
        .DEPTH (INST_DEPTH)
    ) u_place_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata ({s_pin.new_x, s_pin.new_y}),
        .i_re    (ram_re),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_pin.ready) begin
            r_s1_valid <= accept && fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_empty    <= (s_pin.mode == MODE_EMPTY);
            r_s1_in_range <= in_range;
            r_s1_last     <= s_pin.last_pin;
            r_s1_tag      <= s_pin.net_tag;
            r_s1_off_x    <= s_pin.pin_off_x;
            r_s1_off_y    <= s_pin.pin_off_y;
        end
    end

    // A pin of an instance beyond the table takes its offset from the origin.
    assign base_x = r_s1_in_range ? rdata[PLACE_W-1:COORD_W] : '0;
    assign base_y = r_s1_in_range ? rdata[COORD_W-1:0]       : '0;

    assign o_push.valid        = r_s1_valid;
    assign o_push.job.is_empty = r_s1_empty;
    assign o_push.job.last     = r_s1_last;
    assign o_push.job.tag      = r_s1_tag;
    assign o_push.job.px       = base_x + r_s1_off_x;
    assign o_push.job.py       = base_y + r_s1_off_y;

endmodule

// ----- rtl/core/nbh_queue.sv -----
// Short job queue that decouples the front end from the back end.
module nbh_queue import nbh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job_beat i_push,
    output logic      o_push_ready,
    output t_job_beat o_head,
    input  logic      i_pop
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic [QUEUE_AW-1:0] n_wp;
    logic [QUEUE_AW-1:0] n_rp;
    logic                full;
    logic                push;
    logic                pop;

    assign full         = r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_push_ready = !full;
    assign push         = i_push.valid && !full;
    assign pop          = i_pop && (r_cnt != '0);
    assign o_head.valid = r_cnt != '0;
    assign o_head.job   = r_mem[r_rp];

    assign n_wp = (r_wp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= n_wp;
            end
            if (pop) begin
                r_rp <= n_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push.job;
        end
    end

endmodule

// ----- rtl/core/nbh_back.sv -----
// Back end: running bounding box, then width and height, then the wirelength sum.
module nbh_back import nbh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job_beat i_head,
    output logic      o_pop,
    nbh_res_if.source m_res
);

    logic                r_await;
    logic [COORD_W-1:0]  r_min_x;
    logic [COORD_W-1:0]  r_max_x;
    logic [COORD_W-1:0]  r_min_y;
    logic [COORD_W-1:0]  r_max_y;
    logic [COORD_W-1:0]  n_min_x;
    logic [COORD_W-1:0]  n_max_x;
    logic [COORD_W-1:0]  n_min_y;
    logic [COORD_W-1:0]  n_max_y;

    logic                r_b1_valid;
    t_box                r_b1;
    logic                r_b2_valid;
    t_box                r_b2;
    logic [WL_W-1:0]     r_b2_dx;
    logic [WL_W-1:0]     r_b2_dy;
    logic                r_o_valid;
    t_box                r_o;
    logic [WL_W-1:0]     r_o_wl;

    logic                emit;
    logic                load_b1;
    logic                load_b2;
    logic                load_o;
    t_job                job;

    assign job     = i_head.job;
    assign load_o  = !r_o_valid || m_res.ready;
    assign load_b2 = !r_b2_valid || load_o;
    assign load_b1 = !r_b1_valid || load_b2;
    assign emit    = job.is_empty || job.last;
    // Pins that do not close a net only touch the running box, so they never wait.
    assign o_pop   = i_head.valid && (!emit || load_b1);

    always_comb begin
        if (r_await) begin
            n_min_x = job.px;
            n_max_x = job.px;
            n_min_y = job.py;
            n_max_y = job.py;
        end else begin
            n_min_x = ($signed(job.px) < $signed(r_min_x)) ? job.px : r_min_x;
            n_max_x = ($signed(job.px) > $signed(r_max_x)) ? job.px : r_max_x;
            n_min_y = ($signed(job.py) < $signed(r_min_y)) ? job.py : r_min_y;
            n_max_y = ($signed(job.py) > $signed(r_max_y)) ? job.py : r_max_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b1;
            r_min_x <= '0;
            r_max_x <= '0;
            r_min_y <= '0;
            r_max_y <= '0;
        end else if (o_pop) begin
            if (job.is_empty) begin
                r_await <= 1'b1;
            end else begin
                r_await <= job.last;
                r_min_x <= n_min_x;
                r_max_x <= n_max_x;
                r_min_y <= n_min_y;
                r_max_y <= n_max_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (load_b1) begin
                r_b1_valid <= o_pop && emit;
            end
            if (load_b2) begin
                r_b2_valid <= r_b1_valid;
            end
            if (load_o) begin
                r_o_valid <= r_b2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_b1 && o_pop && emit) begin
            r_b1.tag <= job.tag;
            if (job.is_empty) begin
                r_b1.min_x <= '0;
                r_b1.max_x <= '0;
                r_b1.min_y <= '0;
                r_b1.max_y <= '0;
            end else begin
                r_b1.min_x <= n_min_x;
                r_b1.max_x <= n_max_x;
                r_b1.min_y <= n_min_y;
                r_b1.max_y <= n_max_y;
            end
        end
        if (load_b2) begin
            r_b2 <= r_b1;
            // Sign-extended differences: max is never below min, so both are never negative.
            r_b2_dx <= {r_b1.max_x[COORD_W-1], r_b1.max_x}
                     - {r_b1.min_x[COORD_W-1], r_b1.min_x};
            r_b2_dy <= {r_b1.max_y[COORD_W-1], r_b1.max_y}
                     - {r_b1.min_y[COORD_W-1], r_b1.min_y};
        end
        if (load_o) begin
            r_o    <= r_b2;
            r_o_wl <= r_b2_dx + r_b2_dy;
        end
    end

    assign m_res.valid       = r_o_valid;
    assign m_res.net_tag_out = r_o.tag;
    assign m_res.box_min_x   = r_o.min_x;
    assign m_res.box_max_x   = r_o.max_x;
    assign m_res.box_min_y   = r_o.min_y;
    assign m_res.box_max_y   = r_o.max_y;
    assign m_res.wirelength  = r_o_wl;

endmodule

// ----- rtl/core/net_bbox_hpwl_engine_core.sv -----
// Top level of the net bounding box and half-perimeter wirelength engine.
// The engine takes one beat per clock cycle on i_pin while ready is high: a
// move beat writes an instance position into the placement RAM, a pin beat
// adds its offset to its instance position (wrapping at 32 bits) and widens
// the running box, and an empty-net beat produces a result with an all-zero
// box and wirelength. The beat that carries the last pin of a net produces
// one result on o_res: the box and the sum of its width and height as a
// 33-bit value. The front end reads the placement RAM when a pin beat is
// accepted and forms the pin position in the next cycle; a four-entry queue
// then feeds the back end, which registers the box in stage b1, the width and
// height in stage b2 and the wirelength in the output stage. Throughput is
// one beat per cycle unless a full queue holds off i_pin, set by the single
// placement RAM port pair; pins of unmoved instances have undefined positions.
module net_bbox_hpwl_engine_core import nbh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nbh_pin_if.sink   i_pin,
    nbh_res_if.source o_res
);

    t_job_beat push;
    logic      push_ready;
    t_job_beat head;
    logic      pop;

    nbh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_pin        (i_pin),
        .i_push_ready (push_ready),
        .o_push       (push)
    );

    nbh_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_head       (head),
        .i_pop        (pop)
    );

    nbh_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .m_res   (o_res)
    );

`ifndef ASSERT_OFF
    a_pop_needs_job : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("back end popped an empty queue");

    a_stalled_job_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.valid && !push_ready) |=> (push.valid && $stable(push.job)))
        else $error("front end changed a job the queue had not taken");

    a_box_ordered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.box_max_x >= o_res.box_min_x)
                      && (o_res.box_max_y >= o_res.box_min_y)))
        else $error("result box has max below min");
`endif

endmodule

// ----- tb/sv/net_bbox_hpwl_engine_core_tb.sv -----
// Self-checking testbench for the net bounding box and wirelength engine.
module net_bbox_hpwl_engine_core_tb;
    import nbh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 1600;
    localparam int IDLE_PCT      = 19;
    localparam int HOLD_START    = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int CALM_FIRST    = 900;
    localparam int CALM_LAST     = 1200;
    localparam int QUIET_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int SHOWN_ERRORS  = 10;

    typedef struct {
        logic [1:0]                mode;
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic                      last;
        logic [TAG_W-1:0]          tag;
    } t_pin_beat;

    typedef struct {
        logic [TAG_W-1:0]          tag;
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_y;
        logic [WL_W-1:0]           wl;
    } t_box_result;

    typedef struct {
        t_pin_beat   beat;
        bit          typed;
        t_box_result box;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    nbh_pin_if pin_ch ();
    nbh_res_if res_ch ();

    net_bbox_hpwl_engine_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pin   (pin_ch),
        .o_res   (res_ch)
    );

    always #6 clk = ~clk;

    // Predictor state: placement table and the box of the net being gathered.
    logic [COORD_W-1:0] place_x [INST_DEPTH];
    logic [COORD_W-1:0] place_y [INST_DEPTH];
    logic [COORD_W-1:0] box_lo_x, box_hi_x, box_lo_y, box_hi_y;
    bit                 net_fresh = 1'b1;

    // Generator bookkeeping, so that pins only name instances already placed.
    bit [INST_DEPTH-1:0] placed = '0;
    int                  placed_list[$];

    t_stim_row   stim[$];
    t_box_result pending_boxes[$];
    int          stim_idx = 0;
    int          n_errors = 0;
    int          n_moves = 0, n_pins = 0, n_empty = 0, n_ignored = 0, n_checked = 0;
    bit          calm;

    function automatic bit hpwl_predict(input t_pin_beat b, output t_box_result r);
        logic [COORD_W-1:0] bx, by, px, py;
        logic [WL_W-1:0]    dx, dy;
        r = '{default: '0};
        case (b.mode)
            MODE_MOVE: begin
                place_x[b.idx] = b.nx;
                place_y[b.idx] = b.ny;
                return 1'b0;
            end
            MODE_EMPTY: begin
                net_fresh = 1'b1;
                r.tag = b.tag;
                return 1'b1;
            end
            MODE_PIN: begin
                bx = place_x[b.idx];
                by = place_y[b.idx];
                px = bx + b.ox;
                py = by + b.oy;
                if (net_fresh) begin
                    box_lo_x = px;
                    box_hi_x = px;
                    box_lo_y = py;
                    box_hi_y = py;
                end else begin
                    if ($signed(px) < $signed(box_lo_x)) box_lo_x = px;
                    if ($signed(px) > $signed(box_hi_x)) box_hi_x = px;
                    if ($signed(py) < $signed(box_lo_y)) box_lo_y = py;
                    if ($signed(py) > $signed(box_hi_y)) box_hi_y = py;
                end
                if (!b.last) begin
                    net_fresh = 1'b0;
                    return 1'b0;
                end
                // Sign-extended differences are never negative and fit in 33 bits.
                dx = {box_hi_x[COORD_W-1], box_hi_x} - {box_lo_x[COORD_W-1], box_lo_x};
                dy = {box_hi_y[COORD_W-1], box_hi_y} - {box_lo_y[COORD_W-1], box_lo_y};
                r.tag   = b.tag;
                r.min_x = box_lo_x;
                r.max_x = box_hi_x;
                r.min_y = box_lo_y;
                r.max_y = box_hi_y;
                r.wl    = dx + dy;
                net_fresh = 1'b1;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_pin_beat mk_beat(input logic [1:0] mode, input int idx,
                                          input logic [31:0] nx, input logic [31:0] ny,
                                          input logic [31:0] ox, input logic [31:0] oy,
                                          input logic last, input logic [15:0] tag);
        t_pin_beat b;
        b.mode = mode;
        b.idx  = idx[IDX_W-1:0];
        b.nx   = nx;
        b.ny   = ny;
        b.ox   = ox;
        b.oy   = oy;
        b.last = last;
        b.tag  = tag;
        return b;
    endfunction

    function automatic t_box_result mk_box(input logic [15:0] tag,
                                           input logic [31:0] lx, input logic [31:0] hx,
                                           input logic [31:0] ly, input logic [31:0] hy,
                                           input logic [32:0] wl);
        t_box_result r;
        r.tag   = tag;
        r.min_x = lx;
        r.max_x = hx;
        r.min_y = ly;
        r.max_y = hy;
        r.wl    = wl;
        return r;
    endfunction

    task automatic add_row(input t_pin_beat b, input bit typed = 1'b0,
                           input t_box_result box = '{default: '0});
        if (b.mode == MODE_MOVE && !placed[b.idx]) begin
            placed[b.idx] = 1'b1;
            placed_list.push_back(b.idx);
        end
        stim.push_back('{beat: b, typed: typed, box: box});
    endtask

    // Coordinates lean towards the edges of the signed range so that sums wrap often.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom;
            3, 4:    return $urandom_range(0, 255) - 128;
            5: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            6:       return 32'h7FFF_FF00 + $urandom_range(0, 255);
            default: return 32'h8000_0000 + $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int pick_placed();
        return placed_list[$urandom_range(0, placed_list.size() - 1)];
    endfunction

    task automatic build_directed();
        t_box_result zero_box;
        zero_box = '{default: '0};
        add_row(mk_beat(MODE_EMPTY, 0, 0, 0, 0, 0, 1'b0, 16'hFFFF), 1'b1,
                mk_box(16'hFFFF, 0, 0, 0, 0, 33'd0));
        add_row(mk_beat(MODE_MOVE, 0, 0, 0, 0, 0, 1'b1, 16'hA5A5));
        add_row(mk_beat(MODE_MOVE, 1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1'b0, 16'h0000));
        add_row(mk_beat(MODE_MOVE, 512, 32'h8000_0000, 32'h8000_0000, 0, 0, 1'b0, 16'h0000));
        // Widest possible box: both corners of the signed plane.
        add_row(mk_beat(MODE_PIN, 1023, 0, 0, 0, 0, 1'b0, 16'h0000));
        add_row(mk_beat(MODE_PIN, 512, 0, 0, 0, 0, 1'b1, 16'h1234), 1'b1,
                mk_box(16'h1234, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 33'h1_FFFF_FFFE));
        add_row(mk_beat(MODE_PIN, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'h0000),
                1'b1,
                mk_box(16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h8000_0000, 33'd0));
        // Offsets that wrap past the top and the bottom of the range.
        add_row(mk_beat(MODE_PIN, 1023, 0, 0, 1, 1, 1'b1, 16'h00FF), 1'b1,
                mk_box(16'h00FF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 33'd0));
        add_row(mk_beat(MODE_PIN, 512, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFF00),
                1'b1,
                mk_box(16'hFF00, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 33'd0));
        // An empty net in the middle of a net drops the pins gathered so far.
        add_row(mk_beat(MODE_PIN, 0, 0, 0, 5, 5, 1'b0, 16'h0041));
        add_row(mk_beat(MODE_EMPTY, 0, 0, 0, 0, 0, 1'b0, 16'h0042), 1'b1,
                mk_box(16'h0042, 0, 0, 0, 0, 33'd0));
        add_row(mk_beat(MODE_PIN, 0, 0, 0, -3, 7, 1'b1, 16'h0043), 1'b1,
                mk_box(16'h0043, -3, -3, 7, 7, 33'd0));
        // A move in the middle of a net takes effect for the later pins.
        add_row(mk_beat(MODE_PIN, 0, 0, 0, 10, 20, 1'b0, 16'h0000));
        add_row(mk_beat(MODE_MOVE, 0, 100, -100, 0, 0, 1'b0, 16'h0000));
        add_row(mk_beat(MODE_PIN, 0, 0, 0, 0, 0, 1'b1, 16'h0044));
        add_row(mk_beat(MODE_MOVE, 0, 0, 0, 0, 0, 1'b0, 16'h0000));
        // The unused mode is ignored even inside a net.
        add_row(mk_beat(MODE_PIN, 0, 0, 0, 1, 1, 1'b0, 16'h0000));
        add_row(mk_beat(2'd3, 1023, '1, '1, '1, '1, 1'b1, 16'hFFFF));
        add_row(mk_beat(MODE_PIN, 1023, 0, 0, 0, 0, 1'b0, 16'h0000));
        add_row(mk_beat(MODE_PIN, 512, 0, 0, 0, 0, 1'b1, 16'h0045));
        add_row(mk_beat(MODE_EMPTY, 1023, '1, '1, '1, '1, 1'b1, 16'h0000), 1'b1, zero_box);
    endtask

    task automatic build_random();
        int counted, npins, r;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 18) begin
                add_row(mk_beat(MODE_MOVE, $urandom_range(0, INST_DEPTH - 1), rand_coord(),
                                rand_coord(), $urandom, $urandom, 1'($urandom_range(0, 1)),
                                16'($urandom)));
                counted++;
            end else if (r < 23) begin
                add_row(mk_beat(MODE_EMPTY, $urandom_range(0, INST_DEPTH - 1), $urandom,
                                $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                                16'($urandom)));
                counted++;
            end else if (r < 26) begin
                add_row(mk_beat(2'd3, $urandom_range(0, INST_DEPTH - 1), $urandom,
                                $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                                16'($urandom)));
            end else begin
                npins = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                    : $urandom_range(1, 6);
                for (int p = 0; p < npins; p++) begin
                    // A few nets are cut short and run on into whatever follows.
                    if (p == npins - 1 && $urandom_range(0, 99) < 6) break;
                    if ($urandom_range(0, 99) < 5) begin
                        add_row(mk_beat(MODE_MOVE, pick_placed(), rand_coord(),
                                        rand_coord(), $urandom, $urandom, 1'b0,
                                        16'($urandom)));
                        counted++;
                    end
                    add_row(mk_beat(MODE_PIN, pick_placed(), $urandom, $urandom,
                                    rand_coord(), rand_coord(), p == npins - 1,
                                    16'($urandom)));
                    counted++;
                end
            end
        end
    endtask

    task automatic take_beat(input t_stim_row row);
        t_box_result r;
        bit          emits;
        emits = hpwl_predict(row.beat, r);
        case (row.beat.mode)
            MODE_MOVE:  n_moves++;
            MODE_PIN:   n_pins++;
            MODE_EMPTY: n_empty++;
            default:    n_ignored++;
        endcase
        if (row.typed) pending_boxes.push_back(row.box);
        else if (emits) pending_boxes.push_back(r);
    endtask

    initial begin
        pin_ch.valid      = 1'b0;
        pin_ch.mode       = MODE_MOVE;
        pin_ch.inst_index = '0;
        pin_ch.new_x      = '0;
        pin_ch.new_y      = '0;
        pin_ch.pin_off_x  = '0;
        pin_ch.pin_off_y  = '0;
        pin_ch.last_pin   = 1'b0;
        pin_ch.net_tag    = '0;
        res_ch.ready      = 1'b0;
    end

    // Both sides run without gaps for a stretch in the middle of the stimulus.
    always_comb calm = (stim_idx >= CALM_FIRST) && (stim_idx < CALM_LAST);

    // Sender.
    always @(posedge clk) begin
        t_stim_row row;
        bit        held;
        if (!rst_n) begin
            pin_ch.valid <= 1'b0;
        end else begin
            held = pin_ch.valid && !pin_ch.ready;
            if (pin_ch.valid && pin_ch.ready) begin
                take_beat(stim[stim_idx]);
                stim_idx++;
            end
            if (!held) begin
                if (stim_idx < stim.size() && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    row = stim[stim_idx];
                    pin_ch.valid      <= 1'b1;
                    pin_ch.mode       <= row.beat.mode;
                    pin_ch.inst_index <= row.beat.idx;
                    pin_ch.new_x      <= row.beat.nx;
                    pin_ch.new_y      <= row.beat.ny;
                    pin_ch.pin_off_x  <= row.beat.ox;
                    pin_ch.pin_off_y  <= row.beat.oy;
                    pin_ch.last_pin   <= row.beat.last;
                    pin_ch.net_tag    <= row.beat.tag;
                end else begin
                    pin_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver and result checker.
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge clk) begin
        t_box_result want, got;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = mk_box(res_ch.net_tag_out, res_ch.box_min_x, res_ch.box_max_x,
                             res_ch.box_min_y, res_ch.box_max_y, res_ch.wirelength);
                if (pending_boxes.size() == 0) begin
                    n_errors++;
                    if (n_errors <= SHOWN_ERRORS)
                        $display("ERROR: unexpected result tag=%h box=(%0d..%0d, %0d..%0d) wl=%0d",
                                 got.tag, got.min_x, got.max_x, got.min_y, got.max_y, got.wl);
                end else begin
                    want = pending_boxes.pop_front();
                    n_checked++;
                    if (got.tag !== want.tag || got.min_x !== want.min_x ||
                        got.max_x !== want.max_x || got.min_y !== want.min_y ||
                        got.max_y !== want.max_y || got.wl !== want.wl) begin
                        n_errors++;
                        if (n_errors <= SHOWN_ERRORS) begin
                            $display("ERROR: box %0d expected tag=%h x=%0d..%0d y=%0d..%0d wl=%0d",
                                     n_checked, want.tag, want.min_x, want.max_x,
                                     want.min_y, want.max_y, want.wl);
                            $display("       got              tag=%h x=%0d..%0d y=%0d..%0d wl=%0d",
                                     got.tag, got.min_x, got.max_x, got.min_y, got.max_y,
                                     got.wl);
                        end
                    end
                end
            end
            // One long hold-off lets the result side back up into the pin side.
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (!hold_done && stim_idx >= HOLD_START) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog on cycles without any beat on either channel.
    int quiet = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((pin_ch.valid && pin_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QUIET_LIMIT) begin
                    $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                             quiet, pending_boxes.size());
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    initial begin
        build_directed();
        build_random();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_idx == stim.size());
        wait (pending_boxes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_boxes.size() != 0) n_errors++;
        $display("Run covered %0d moves, %0d pins, %0d empty nets and %0d ignored beats.",
                 n_moves, n_pins, n_empty, n_ignored);
        $display("%0d boxes were checked, %0d mismatches found.", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
